[rtl/core/glb_pkg.sv]
// ----------------------------------------------------------------------------
// glb_pkg
// shared types, widths and cell commands of the greedy load assigner
// ----------------------------------------------------------------------------
package glb_pkg;

    localparam int MAX_TASKS   = 32;
    localparam int MAX_BUNCHES = 4096;

    localparam int COST_W  = 48;   // cost totals and mean
    localparam int BCOST_W = 40;   // cost of one bunch
    localparam int PART_W  = 31;   // particle counts
    localparam int POS_W   = 12;   // key positions
    localparam int TASK_W  = 5;    // task number
    localparam int CNT_W   = 6;    // task count register
    localparam int SCAN_W  = $clog2(MAX_TASKS);

    localparam logic [POS_W-1:0] KEY_MAX = POS_W'(MAX_BUNCHES - 1);

    // cell commands
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [TASK_W-1:0] task_sel;
    } t_cell_ctl;

    // running best deficit passed along the chain
    typedef struct packed {
        logic [COST_W-1:0] delta;
        logic [TASK_W-1:0] task_sel;
    } t_tok;

    // per-task state held by one cell
    typedef struct packed {
        logic [COST_W-1:0]  cost_sum;
        logic [PART_W-1:0]  part_sum;
        logic [BCOST_W-1:0] best_cost;
        logic [POS_W-1:0]   best_pos;
        logic               seen;
    } t_task_st;

endpackage

[rtl/core/glb_cell.sv]
// ----------------------------------------------------------------------------
// glb_cell
// one task slot: holds the task totals, compares its deficit against the
// token from its neighbor and passes the better one on
// ----------------------------------------------------------------------------
module glb_cell
    import glb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TASK_W-1:0]  i_idx,
    input  logic               i_active,
    input  logic [COST_W-1:0]  i_mean,
    input  t_cell_ctl          i_ctl,
    input  logic [BCOST_W-1:0] i_cost,
    input  logic [PART_W-1:0]  i_parts,
    input  logic [POS_W-1:0]   i_pos,
    input  t_tok               i_tok,
    output t_tok               o_tok,
    input  t_task_st           i_nbr,
    output t_task_st           o_st
);

    t_task_st             r_st;
    t_task_st             n_st;
    t_tok                 r_tok;
    t_tok                 n_tok;
    logic [COST_W-1:0]    deficit;
    logic [COST_W:0]      cost_add;
    logic [PART_W:0]      part_add;
    logic                 better;

    // deficit below the mean, zero when at or above it
    always_comb begin
        deficit = (i_mean > r_st.cost_sum) ? (i_mean - r_st.cost_sum) : '0;
        n_tok   = i_tok;
        if (i_active && (deficit > i_tok.delta)) begin
            n_tok.delta    = deficit;
            n_tok.task_sel = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    always_comb begin
        cost_add = {1'b0, r_st.cost_sum} + {(COST_W - BCOST_W + 1)'(0), i_cost};
        part_add = {1'b0, r_st.part_sum} + {1'b0, i_parts};
        better   = !r_st.seen || (i_cost > r_st.best_cost)
                   || ((i_cost == r_st.best_cost) && (i_pos < r_st.best_pos));
        n_st     = r_st;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_st = r_st;
            end
            OP_ADD: begin
                if (i_ctl.task_sel == i_idx) begin
                    n_st.cost_sum = cost_add[COST_W] ? '1 : cost_add[COST_W-1:0];
                    n_st.part_sum = part_add[PART_W] ? '1 : part_add[PART_W-1:0];
                    if (better) begin
                        n_st.seen      = 1'b1;
                        n_st.best_cost = i_cost;
                        n_st.best_pos  = i_pos;
                    end
                end
            end
            OP_SHIFT: begin
                n_st = i_nbr;
            end
            OP_CLEAR: begin
                n_st = '0;
            end
            default: begin
                n_st = r_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_tok = r_tok;
    assign o_st  = r_st;

endmodule

[rtl/core/greedy_load_assigner.sv]
// ----------------------------------------------------------------------------
// greedy_load_assigner
// greedy largest-deficit assignment of work bunches to tasks
//
// Bunches arrive in descending cost order and each one goes to the task whose
// cost total lies furthest below the configured mean cost (strictly positive
// deficit, ties to the lowest task, task 0 when no task is below the mean).
// Every task lives in one cell of a chain of MAX_TASKS cells; a token carrying
// the best deficit so far walks the chain one cell per clock, so each bunch
// first searches the whole chain, then posts its assignment once the output
// register is free and returns to idle. A bunch flagged final_bunch adds a
// summary pass with one summary per active task, during which the chain shifts
// its task records toward cell 0 to emit the summaries, and the last summary
// clears every cell. Only one bunch is in flight; o_stall stays high until its
// results are handed to the output register.
// Configuration writes are taken at any time on their own channel (ready is
// always high) and must only come while no bunch is in flight.
// ----------------------------------------------------------------------------
module greedy_load_assigner
    import glb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration transactions
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [COST_W-1:0]  i_cfg_data,
    // bunch transactions in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BCOST_W-1:0] i_bunch_cost,
    input  logic [PART_W-1:0]  i_bunch_particles,
    input  logic [POS_W-1:0]   i_key_position,
    input  logic               i_final_bunch,
    // result transactions out
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [TASK_W-1:0]  o_task_res,
    output logic [COST_W-1:0]  o_total_cost,
    output logic [PART_W-1:0]  o_total_particles,
    output logic [POS_W-1:0]   o_split_position,
    output logic               o_split_valid,
    output logic               o_run_end
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    // register indexes
    localparam logic CFG_MEAN  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // result kinds
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_SUM    = 1'b1;

    // configuration registers
    logic [COST_W-1:0]  r_mean;
    logic [CNT_W-1:0]   r_tcount;

    // sequencer
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [SCAN_W-1:0]  r_scnt;
    logic [TASK_W-1:0]  r_sidx;

    // latched bunch
    logic [BCOST_W-1:0] r_cost;
    logic [PART_W-1:0]  r_parts;
    logic [POS_W-1:0]   r_pos;
    logic               r_final;

    // output register
    logic               r_ovalid;
    logic               r_okind;
    logic [TASK_W-1:0]  r_otask;
    logic [COST_W-1:0]  r_ocost;
    logic [PART_W-1:0]  r_oparts;
    logic [POS_W-1:0]   r_opos;
    logic               r_osvalid;
    logic               r_oend;

    logic               in_acc;
    logic               out_free;
    logic               emit;
    logic               sum_last;
    logic [CNT_W-1:0]   n_act;
    logic [TASK_W-1:0]  last_task;
    t_cell_ctl          cell_ctl;

    t_tok               tok_in  [MAX_TASKS];
    t_tok               tok_out [MAX_TASKS];
    t_task_st           st      [MAX_TASKS];
    t_task_st           nbr     [MAX_TASKS];
    logic [MAX_TASKS-1:0] active;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_ovalid || !i_stall;

    // task count clamped into 1..MAX_TASKS
    always_comb begin
        if (r_tcount == '0) begin
            n_act = CNT_W'(1);
        end else if (r_tcount > CNT_W'(MAX_TASKS)) begin
            n_act = CNT_W'(MAX_TASKS);
        end else begin
            n_act = r_tcount;
        end
    end
    assign last_task = TASK_W'(n_act - CNT_W'(1));
    assign sum_last  = (r_sidx == last_task);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_tcount <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MEAN:  r_mean   <= i_cfg_data;
                CFG_COUNT: r_tcount <= i_cfg_data[CNT_W-1:0];
                default:   r_mean   <= r_mean;
            endcase
        end
    end

    // bunch latch, key position clamped to the key range
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cost  <= i_bunch_cost;
            r_parts <= i_bunch_particles;
            r_pos   <= (i_key_position > KEY_MAX) ? KEY_MAX : i_key_position;
            r_final <= i_final_bunch;
        end
    end

    // sequencer and cell commands
    always_comb begin
        n_state           = r_state;
        emit              = 1'b0;
        cell_ctl.op       = OP_HOLD;
        cell_ctl.task_sel = tok_out[MAX_TASKS-1].task_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // wait for the token to reach the end of the chain
                if (r_scnt == SCAN_W'(MAX_TASKS - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    emit        = 1'b1;
                    cell_ctl.op = OP_ADD;
                    n_state     = r_final ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (sum_last) begin
                        cell_ctl.op = OP_CLEAR;
                        n_state     = ST_IDLE;
                    end else begin
                        cell_ctl.op = OP_SHIFT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scnt  <= '0;
            r_sidx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_scnt <= r_scnt + SCAN_W'(1);
            end else begin
                r_scnt <= '0;
            end
            if (r_state == ST_SUM) begin
                if (emit) begin
                    r_sidx <= r_sidx + TASK_W'(1);
                end
            end else begin
                r_sidx <= '0;
            end
        end
    end

    // output register, free again once the consumer takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_state == ST_UPD) begin
                r_okind   <= KIND_ASSIGN;
                r_otask   <= tok_out[MAX_TASKS-1].task_sel;
                r_ocost   <= '0;
                r_oparts  <= '0;
                r_opos    <= '0;
                r_osvalid <= 1'b0;
                r_oend    <= !r_final;
            end else begin
                // cell 0 holds the record of task r_sidx after r_sidx shifts
                r_okind   <= KIND_SUM;
                r_otask   <= r_sidx;
                r_ocost   <= st[0].cost_sum;
                r_oparts  <= st[0].part_sum;
                r_opos    <= st[0].seen ? st[0].best_pos : '0;
                r_osvalid <= st[0].seen;
                r_oend    <= sum_last;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_kind            = r_okind;
    assign o_task_res        = r_otask;
    assign o_total_cost      = r_ocost;
    assign o_total_particles = r_oparts;
    assign o_split_position  = r_opos;
    assign o_split_valid     = r_osvalid;
    assign o_run_end         = r_oend;

    // chain of task cells: tokens move up, records shift down toward cell 0
    for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign tok_in[j] = '0;
        end else begin : g_link
            assign tok_in[j] = tok_out[j-1];
        end
        if (j == MAX_TASKS - 1) begin : g_tail
            assign nbr[j] = '0;
        end else begin : g_next
            assign nbr[j] = st[j+1];
        end
        assign active[j] = (CNT_W'(j) < n_act);

        glb_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (TASK_W'(j)),
            .i_active (active[j]),
            .i_mean   (r_mean),
            .i_ctl    (cell_ctl),
            .i_cost   (r_cost),
            .i_parts  (r_parts),
            .i_pos    (r_pos),
            .i_tok    (tok_in[j]),
            .o_tok    (tok_out[j]),
            .i_nbr    (nbr[j]),
            .o_st     (st[j])
        );
    end

    // an accepted bunch always starts the deficit search
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SCAN))
        else $error("accepted bunch did not start the search");

    // the winning task is one of the active tasks
    a_winner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ({1'b0, tok_out[MAX_TASKS-1].task_sel} < n_act))
        else $error("winning task outside the active range");

    // summaries only come after a final bunch
    a_sum_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> r_final)
        else $error("summary pass without final bunch");

    // the last summary leaves the chain cleared
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SUM) && emit && sum_last) |=>
            (!st[0].seen && (st[0].cost_sum == '0) && (st[0].part_sum == '0)))
        else $error("task records not cleared after summaries");

endmodule
